// ----- sv/fcr_pkg.sv -----
`default_nettype none
package fcr_pkg;

   localparam int unsigned FAT_END_THRESHOLD = 32'h0FFF_FFF7;

   localparam logic [2:0] REG_BYTES_PER_SECTOR    = 3'd0;
   localparam logic [2:0] REG_SECTORS_PER_CLUSTER = 3'd1;
   localparam logic [2:0] REG_RESERVED_SECTORS    = 3'd2;
   localparam logic [2:0] REG_FAT_COUNT           = 3'd3;
   localparam logic [2:0] REG_FAT_SECTORS         = 3'd4;

   localparam logic [12:0] BPS_RESET = 13'd512;
   localparam logic [5:0]  SPC_RESET = 6'd8;
   localparam logic [15:0] RSV_RESET = 16'd32;
   localparam logic [2:0]  FCN_RESET = 3'd2;
   localparam logic [31:0] FSZ_RESET = 32'd0;

   typedef enum logic [1:0] {
      KIND_START = 2'd0,
      KIND_NEXT  = 2'd1,
      KIND_END   = 2'd2
   } cmd_op_type;

   typedef enum logic [1:0] {
      REQ_SECTOR = 2'd0,
      REQ_FAT    = 2'd1,
      REQ_DONE   = 2'd2
   } req_kind_type;

   typedef struct packed {
      cmd_op_type  op;
      logic [31:0] cluster;
      logic [31:0] length;
   } cmd_type;

   typedef struct packed {
      req_kind_type request_type;
      logic [31:0]  byte_offset;
      logic [12:0]  byte_count;
      logic         last;
   } rsp_type;

   typedef struct packed {
      logic [12:0] bytes_per_sector;
      logic [5:0]  sectors_per_cluster;
      logic [15:0] reserved_sectors;
      logic [2:0]  fat_count;
      logic [31:0] fat_sectors;
   } cfg_type;

endpackage
`default_nettype wire

// ----- sv/fcr_fifo.sv -----
`default_nettype none
module fcr_fifo #(
   parameter int unsigned WIDTH = 48,
   parameter int unsigned DEPTH = 2
) (
   input  wire              clock,
   input  wire              reset,
   input  wire              push,
   input  wire [WIDTH-1:0]  wr_data,
   output logic             full,
   input  wire              pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);
   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full    = (cnt_ff == CNT_W'(DEPTH));
   assign empty   = (cnt_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end
endmodule
`default_nettype wire

// ----- sv/fcr_front.sv -----
`default_nettype none
module fcr_front (
   input  wire               clock,
   input  wire               reset,
   input  wire               push,
   input  wire               kind,
   input  wire [31:0]        cluster_value,
   input  wire [31:0]        file_length,
   input  wire               cmd_full,
   output logic              cmd_push,
   output fcr_pkg::cmd_type  cmd
);
   import fcr_pkg::*;

   logic active_ff, active_in;
   logic accept;

   assign accept = push && !cmd_full;

   always_comb begin
      active_in   = active_ff;
      cmd_push    = 1'b0;
      cmd.cluster = cluster_value;
      cmd.length  = file_length;
      cmd.op      = KIND_START;
      if (accept) begin
         priority if (!kind) begin
            active_in = 1'b1;
            cmd_push  = 1'b1;
         end else if (!active_ff) begin
            // drop entries arriving with no chain open
            cmd_push = 1'b0;
         end else if (cluster_value < FAT_END_THRESHOLD) begin
            cmd.op   = KIND_NEXT;
            cmd_push = 1'b1;
         end else begin
            cmd.op    = KIND_END;
            cmd_push  = 1'b1;
            active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
      end
   end
endmodule
`default_nettype wire

// ----- sv/fcr_back.sv -----
`default_nettype none
module fcr_back #(
   parameter int unsigned MAX_SECTORS_PER_CLUSTER = 32
) (
   input  wire               clock,
   input  wire               reset,
   input  fcr_pkg::cfg_type  cfg,
   input  fcr_pkg::cmd_type  cmd,
   input  wire               cmd_empty,
   output logic              cmd_pop,
   input  wire               rsp_full,
   output logic              rsp_push,
   output fcr_pkg::rsp_type  rsp
);
   import fcr_pkg::*;

   localparam int unsigned SEC_W = $clog2(MAX_SECTORS_PER_CLUSTER + 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL,
      S_SUM,
      S_SECT,
      S_FAT,
      S_END
   } state_type;

   state_type        state_ff, state_in;
   logic [31:0]      cluster_ff, cluster_in;
   logic [31:0]      remain_ff, remain_in;
   logic [31:0]      t1_ff, t1_in;
   logic [31:0]      t2_ff, t2_in;
   logic [31:0]      t3_ff, t3_in;
   logic [31:0]      off_ff, off_in;
   logic [SEC_W-1:0] sec_ff, sec_in;
   logic [SEC_W-1:0] lim_ff, lim_in;
   logic [31:0]      cm2;
   logic [31:0]      bps32;

   assign bps32 = {19'd0, cfg.bytes_per_sector};
   assign cm2   = (cluster_ff <= 32'd1) ? 32'd0 : cluster_ff - 32'd2;

   always_comb begin
      state_in   = state_ff;
      cluster_in = cluster_ff;
      remain_in  = remain_ff;
      t1_in      = t1_ff;
      t2_in      = t2_ff;
      t3_in      = t3_ff;
      off_in     = off_ff;
      sec_in     = sec_ff;
      lim_in     = lim_ff;
      cmd_pop    = 1'b0;
      rsp_push   = 1'b0;
      rsp.request_type = REQ_SECTOR;
      rsp.byte_offset  = off_ff;
      rsp.byte_count   = cfg.bytes_per_sector;
      rsp.last         = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop = 1'b1;
               t1_in = 32'({19'd0, cfg.bytes_per_sector} * {26'd0, cfg.sectors_per_cluster});
               t2_in = 32'({19'd0, cfg.bytes_per_sector} * {16'd0, cfg.reserved_sectors});
               t3_in = 32'({29'd0, cfg.fat_count} * cfg.fat_sectors);
               if ({26'd0, cfg.sectors_per_cluster} > 32'(MAX_SECTORS_PER_CLUSTER)) begin
                  lim_in = SEC_W'(MAX_SECTORS_PER_CLUSTER);
               end else begin
                  lim_in = SEC_W'(cfg.sectors_per_cluster);
               end
               unique case (cmd.op)
                  KIND_START: begin
                     cluster_in = cmd.cluster;
                     remain_in  = cmd.length;
                     state_in   = S_MUL;
                  end
                  KIND_NEXT: begin
                     cluster_in = cmd.cluster;
                     state_in   = S_MUL;
                  end
                  KIND_END: begin
                     state_in = S_END;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_MUL: begin
            t1_in    = 32'(cm2 * t1_ff);
            t3_in    = 32'(t3_ff * bps32);
            state_in = S_SUM;
         end
         S_SUM: begin
            off_in   = t1_ff + t2_ff + t3_ff;
            sec_in   = '0;
            state_in = (lim_ff == '0) ? S_FAT : S_SECT;
         end
         S_SECT: begin
            if (!rsp_full) begin
               rsp_push = 1'b1;
               off_in   = off_ff + bps32;
               sec_in   = sec_ff + 1'b1;
               if (remain_ff < bps32) begin
                  rsp.byte_count = remain_ff[12:0];
                  remain_in      = '0;
                  state_in       = S_FAT;
               end else begin
                  remain_in = remain_ff - bps32;
                  if ({1'b0, sec_ff} + 1'b1 == {1'b0, lim_ff}) begin
                     state_in = S_FAT;
                  end
               end
            end
         end
         S_FAT: begin
            rsp.request_type = REQ_FAT;
            rsp.byte_offset  = t2_ff + {cluster_ff[29:0], 2'b00};
            rsp.byte_count   = '0;
            rsp.last         = 1'b1;
            if (!rsp_full) begin
               rsp_push = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_END: begin
            rsp.request_type = REQ_DONE;
            rsp.byte_offset  = '0;
            rsp.byte_count   = '0;
            rsp.last         = 1'b1;
            if (!rsp_full) begin
               rsp_push = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         cluster_ff <= '0;
         remain_ff  <= '0;
      end else begin
         state_ff   <= state_in;
         cluster_ff <= cluster_in;
         remain_ff  <= remain_in;
      end
      t1_ff  <= t1_in;
      t2_ff  <= t2_in;
      t3_ff  <= t3_in;
      off_ff <= off_in;
      sec_ff <= sec_in;
      lim_ff <= lim_in;
   end
endmodule
`default_nettype wire

// ----- sv/fat32_cluster_chain_reader.sv -----
// An item reaches the sequencer through the command queue; a cluster then needs
// three set-up steps (load, multiply, sum) before its first result.
// One result a cycle once started, while the result queue is not full; the
// sequencer takes no new item until a cluster's FAT read or a chain end is queued.
// Reset: synchronous; empties both queues, closes the chain and loads the
// register defaults.
`default_nettype none
module fat32_cluster_chain_reader #(
   parameter int unsigned MAX_SECTORS_PER_CLUSTER = 32
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         push,
   output logic        full,
   input  wire         req_kind,
   input  wire [31:0]  req_cluster_value,
   input  wire [31:0]  req_file_length,
   output logic        empty,
   input  wire         pop,
   output logic [1:0]  rsp_request_type,
   output logic [31:0] rsp_byte_offset,
   output logic [12:0] rsp_byte_count,
   output logic        rsp_last,
   input  wire         psel,
   input  wire         penable,
   input  wire         pwrite,
   input  wire [4:0]   paddr,
   input  wire [31:0]  pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import fcr_pkg::*;

   localparam int unsigned CMD_W = $bits(cmd_type);
   localparam int unsigned RSP_W = $bits(rsp_type);

   cfg_type    cfg_ff;
   logic [2:0] reg_idx;
   logic       cfg_wr;

   cmd_type    front_cmd, back_cmd;
   logic       cmd_push, cmd_full, cmd_pop, cmd_empty;
   rsp_type    back_rsp, head_rsp;
   logic       rsp_push, rsp_full;

   assign pready  = 1'b1;
   assign reg_idx = paddr[4:2];
   assign cfg_wr  = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bytes_per_sector    <= BPS_RESET;
         cfg_ff.sectors_per_cluster <= SPC_RESET;
         cfg_ff.reserved_sectors    <= RSV_RESET;
         cfg_ff.fat_count           <= FCN_RESET;
         cfg_ff.fat_sectors         <= FSZ_RESET;
      end else if (cfg_wr) begin
         unique case (reg_idx)
            REG_BYTES_PER_SECTOR:    cfg_ff.bytes_per_sector    <= pwdata[12:0];
            REG_SECTORS_PER_CLUSTER: cfg_ff.sectors_per_cluster <= pwdata[5:0];
            REG_RESERVED_SECTORS:    cfg_ff.reserved_sectors    <= pwdata[15:0];
            REG_FAT_COUNT:           cfg_ff.fat_count           <= pwdata[2:0];
            REG_FAT_SECTORS:         cfg_ff.fat_sectors         <= pwdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_BYTES_PER_SECTOR:    prdata = {19'd0, cfg_ff.bytes_per_sector};
         REG_SECTORS_PER_CLUSTER: prdata = {26'd0, cfg_ff.sectors_per_cluster};
         REG_RESERVED_SECTORS:    prdata = {16'd0, cfg_ff.reserved_sectors};
         REG_FAT_COUNT:           prdata = {29'd0, cfg_ff.fat_count};
         REG_FAT_SECTORS:         prdata = cfg_ff.fat_sectors;
         default:                 prdata = '0;
      endcase
   end

   fcr_front u_front (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .kind          (req_kind),
      .cluster_value (req_cluster_value),
      .file_length   (req_file_length),
      .cmd_full      (cmd_full),
      .cmd_push      (cmd_push),
      .cmd           (front_cmd)
   );

   fcr_fifo #(
      .WIDTH (CMD_W),
      .DEPTH (2)
   ) u_cmd_q (
      .clock   (clock),
      .reset   (reset),
      .push    (cmd_push),
      .wr_data (front_cmd),
      .full    (cmd_full),
      .pop     (cmd_pop),
      .rd_data (back_cmd),
      .empty   (cmd_empty)
   );

   fcr_back #(
      .MAX_SECTORS_PER_CLUSTER (MAX_SECTORS_PER_CLUSTER)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd       (back_cmd),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp       (back_rsp)
   );

   fcr_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (2)
   ) u_rsp_q (
      .clock   (clock),
      .reset   (reset),
      .push    (rsp_push),
      .wr_data (back_rsp),
      .full    (rsp_full),
      .pop     (pop),
      .rd_data (head_rsp),
      .empty   (empty)
   );

   assign full             = cmd_full;
   assign rsp_request_type = head_rsp.request_type;
   assign rsp_byte_offset  = head_rsp.byte_offset;
   assign rsp_byte_count   = head_rsp.byte_count;
   assign rsp_last         = head_rsp.last;

   a_reset_empties: assert property (@(posedge clock)
      reset |=> !full && empty)
      else $error("queues not empty after reset");

   a_sector_not_last: assert property (@(posedge clock) disable iff (reset)
      !empty && head_rsp.request_type == REQ_SECTOR |-> !head_rsp.last)
      else $error("sector read marked last");

   a_fat_shape: assert property (@(posedge clock) disable iff (reset)
      !empty && head_rsp.request_type != REQ_SECTOR
      |-> head_rsp.last && head_rsp.byte_count == 13'd0)
      else $error("FAT or finished result malformed");

   a_sector_count: assert property (@(posedge clock) disable iff (reset)
      rsp_push && back_rsp.request_type == REQ_SECTOR
      |-> back_rsp.byte_count <= cfg_ff.bytes_per_sector)
      else $error("sector count exceeds sector size");

endmodule
`default_nettype wire

// ----- tb/sv/tb_fat32_cluster_chain_reader.sv -----
`default_nettype none
module tb_fat32_cluster_chain_reader;
   timeunit 1ns;
   timeprecision 1ps;

   import fcr_pkg::*;

   localparam int unsigned MAX_CLUSTER_SECTORS = 32;
   localparam int          SETTLE_CYCLES       = 60;
   localparam int          DRAIN_LIMIT         = 200000;
   localparam int          RANDOM_PHASES       = 8;
   localparam int          ITEMS_PER_PHASE     = 50;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        full;
   logic        req_kind = 1'b0;
   logic [31:0] req_cluster_value = '0;
   logic [31:0] req_file_length = '0;
   logic        empty;
   logic        pop = 1'b0;
   logic [1:0]  rsp_request_type;
   logic [31:0] rsp_byte_offset;
   logic [12:0] rsp_byte_count;
   logic        rsp_last;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [4:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   logic        no_idle = 1'b0;
   int          mismatches = 0;

   cfg_type     volume_cfg;
   logic [31:0] walk_cluster;
   logic [31:0] walk_remaining;
   logic        walk_active;
   rsp_type     pending_requests[$];

   fat32_cluster_chain_reader #(
      .MAX_SECTORS_PER_CLUSTER(MAX_CLUSTER_SECTORS)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .push(push),
      .full(full),
      .req_kind(req_kind),
      .req_cluster_value(req_cluster_value),
      .req_file_length(req_file_length),
      .empty(empty),
      .pop(pop),
      .rsp_request_type(rsp_request_type),
      .rsp_byte_offset(rsp_byte_offset),
      .rsp_byte_count(rsp_byte_count),
      .rsp_last(rsp_last),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(input string what);
      $display("ERROR at %0t: %s", $realtime, what);
      mismatches++;
   endtask

   function automatic void push_request(input req_kind_type kind, input logic [31:0] offset,
                                        input logic [12:0] count, input logic last);
      rsp_type r;
      r.request_type = kind;
      r.byte_offset  = offset;
      r.byte_count   = count;
      r.last         = last;
      pending_requests.push_back(r);
   endfunction

   function automatic void predict_cluster_run();
      logic [31:0] bps, spc, rsv, fcn, cc, base, limit, idx;
      bps = volume_cfg.bytes_per_sector;
      spc = volume_cfg.sectors_per_cluster;
      rsv = volume_cfg.reserved_sectors;
      fcn = volume_cfg.fat_count;
      cc = (walk_cluster <= 32'd1) ? 32'd2 : walk_cluster;
      base = (cc - 32'd2) * bps * spc + bps * rsv + fcn * volume_cfg.fat_sectors * bps;
      limit = (spc > MAX_CLUSTER_SECTORS) ? MAX_CLUSTER_SECTORS : spc;
      for (idx = 0; idx < limit; idx++) begin
         if (walk_remaining < bps) begin
            push_request(REQ_SECTOR, base + idx * bps, walk_remaining[12:0], 1'b0);
            walk_remaining = '0;
            break;
         end
         push_request(REQ_SECTOR, base + idx * bps, bps[12:0], 1'b0);
         walk_remaining = walk_remaining - bps;
      end
      push_request(REQ_FAT, rsv * bps + (walk_cluster << 2), 13'd0, 1'b1);
   endfunction

   function automatic void predict_requests(input cmd_type item);
      if (item.op == KIND_START) begin
         walk_cluster   = item.cluster;
         walk_remaining = item.length;
         walk_active    = 1'b1;
         predict_cluster_run();
      end else if (walk_active) begin
         if (item.cluster < FAT_END_THRESHOLD) begin
            walk_cluster = item.cluster;
            predict_cluster_run();
         end else begin
            walk_active = 1'b0;
            push_request(REQ_DONE, 32'd0, 13'd0, 1'b1);
         end
      end
   endfunction

   function automatic cmd_type file_start(input logic [31:0] cluster, input logic [31:0] length);
      cmd_type c;
      c.op      = KIND_START;
      c.cluster = cluster;
      c.length  = length;
      return c;
   endfunction

   function automatic cmd_type fat_link(input logic [31:0] entry);
      cmd_type c;
      c.op      = KIND_NEXT;
      c.cluster = entry;
      c.length  = $urandom;
      return c;
   endfunction

   task automatic send_item(input cmd_type item);
      while (!no_idle && $urandom_range(0, 99) < 15) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push              <= 1'b1;
      req_kind          <= item.op[0];
      req_cluster_value <= item.cluster;
      req_file_length   <= item.length;
      do @(posedge clock); while (full);
      predict_requests(item);
   endtask

   task automatic drain_requests();
      int waited;
      push <= 1'b0;
      waited = 0;
      while (pending_requests.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (pending_requests.size() != 0) begin
         report_mismatch($sformatf("%0d expected results never arrived",
                                   pending_requests.size()));
         pending_requests.delete();
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] index, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (index)
         REG_BYTES_PER_SECTOR:    volume_cfg.bytes_per_sector    = value[12:0];
         REG_SECTORS_PER_CLUSTER: volume_cfg.sectors_per_cluster = value[5:0];
         REG_RESERVED_SECTORS:    volume_cfg.reserved_sectors    = value[15:0];
         REG_FAT_COUNT:           volume_cfg.fat_count           = value[2:0];
         REG_FAT_SECTORS:         volume_cfg.fat_sectors         = value;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic set_geometry(input logic [31:0] bps, input logic [31:0] spc,
                               input logic [31:0] rsv, input logic [31:0] fcn,
                               input logic [31:0] fsz);
      csr_write(REG_BYTES_PER_SECTOR, bps);
      csr_write(REG_SECTORS_PER_CLUSTER, spc);
      csr_write(REG_RESERVED_SECTORS, rsv);
      csr_write(REG_FAT_COUNT, fcn);
      csr_write(REG_FAT_SECTORS, fsz);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else begin
         pop <= no_idle || ($urandom_range(0, 99) >= 15);
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && pop && !empty) begin
         if (pending_requests.size() == 0) begin
            report_mismatch($sformatf("unexpected result type %0d offset %h count %0d last %0b",
                                      rsp_request_type, rsp_byte_offset, rsp_byte_count,
                                      rsp_last));
         end else begin
            want = pending_requests.pop_front();
            if (rsp_request_type !== want.request_type) begin
               report_mismatch($sformatf("request_type %0d, wanted %0d",
                                         rsp_request_type, want.request_type));
            end
            if (rsp_byte_offset !== want.byte_offset) begin
               report_mismatch($sformatf("byte_offset %h, wanted %h",
                                         rsp_byte_offset, want.byte_offset));
            end
            if (rsp_byte_count !== want.byte_count) begin
               report_mismatch($sformatf("byte_count %0d, wanted %0d",
                                         rsp_byte_count, want.byte_count));
            end
            if (rsp_last !== want.last) begin
               report_mismatch($sformatf("last %0b, wanted %0b", rsp_last, want.last));
            end
         end
      end
   end

   task automatic test_default_geometry();
      send_item(fat_link(32'd5));
      send_item(file_start(32'd2, 32'd5000));
      send_item(fat_link(32'd3));
      send_item(fat_link(32'h0FFF_FFF8));
      drain_requests();
   endtask

   task automatic test_extreme_geometry();
      set_geometry(32'd8191, 32'd63, 32'd65535, 32'd7, 32'hFFFF_FFFF);
      send_item(file_start(32'hFFFF_FFFF, 32'hFFFF_FFFF));
      send_item(fat_link(FAT_END_THRESHOLD - 1));
      send_item(fat_link(FAT_END_THRESHOLD));
      drain_requests();
      set_geometry(32'd1, 32'd1, 32'd0, 32'd0, 32'd0);
      send_item(file_start(32'd0, 32'd0));
      send_item(fat_link(32'd1));
      send_item(file_start(32'd7, 32'd3));
      send_item(fat_link(32'hFFFF_FFFF));
      drain_requests();
   endtask

   task automatic test_degenerate_geometry();
      set_geometry(32'd0, 32'd4, 32'd16, 32'd1, 32'd100);
      send_item(file_start(32'd9, 32'd100));
      send_item(fat_link(32'd10));
      send_item(fat_link(32'hF000_0000));
      drain_requests();
      set_geometry(32'd512, 32'd0, 32'd32, 32'd2, 32'd1000);
      send_item(file_start(32'd4, 32'd1000));
      send_item(fat_link(32'h0FFF_FFFF));
      drain_requests();
   endtask

   task automatic test_random_chains();
      int          sent, roll, links;
      logic [31:0] bps, spc, span;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: set_geometry(32'd512, 32'd8, 32'd32, 32'd2, 32'd1000);
            1: set_geometry(32'd8191, 32'd63, 32'd65535, 32'd7, 32'hFFFF_FFFF);
            2: set_geometry(32'd1, 32'd1, 32'd0, 32'd0, 32'd0);
            default: begin
               roll = $urandom_range(0, 3);
               bps = (roll == 0) ? 32'd1 : (roll == 1) ? 32'd512 :
                     (roll == 2) ? 32'd4096 : $urandom_range(8191, 0);
               set_geometry(bps, $urandom_range(63, 0), $urandom, $urandom_range(7, 0),
                            $urandom);
            end
         endcase
         no_idle = (phase == 3);
         bps = volume_cfg.bytes_per_sector;
         spc = (volume_cfg.sectors_per_cluster > MAX_CLUSTER_SECTORS) ?
               MAX_CLUSTER_SECTORS : volume_cfg.sectors_per_cluster;
         sent = 0;
         while (sent < ITEMS_PER_PHASE) begin
            roll = $urandom_range(0, 99);
            if (roll < 10) begin
               send_item(fat_link($urandom));
            end else if (roll < 16) begin
               send_item(file_start($urandom, $urandom));
               sent++;
            end else begin
               links = $urandom_range(0, 4);
               span  = bps * spc * (links + 1);
               send_item(file_start(($urandom_range(0, 3) == 0) ? $urandom_range(3, 0) : $urandom,
                                    ($urandom_range(0, 9) < 3) ? $urandom :
                                    $urandom_range(span, 0)));
               repeat (links) begin
                  send_item(fat_link(($urandom_range(0, 4) == 0) ? $urandom_range(3, 0) :
                                     $urandom_range(FAT_END_THRESHOLD - 1, 0)));
               end
               send_item(fat_link($urandom_range(32'hFFFF_FFFF, FAT_END_THRESHOLD)));
               sent += links + 2;
            end
         end
         drain_requests();
      end
      no_idle = 1'b0;
   endtask

   initial begin
      volume_cfg.bytes_per_sector    = BPS_RESET;
      volume_cfg.sectors_per_cluster = SPC_RESET;
      volume_cfg.reserved_sectors    = RSV_RESET;
      volume_cfg.fat_count           = FCN_RESET;
      volume_cfg.fat_sectors         = FSZ_RESET;
      walk_cluster   = '0;
      walk_remaining = '0;
      walk_active    = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_default_geometry();
      test_extreme_geometry();
      test_degenerate_geometry();
      test_random_chains();
      drain_requests();
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("FAIL");
      $finish;
   end

endmodule
`default_nettype wire

// ----- files.f -----
sv/fcr_pkg.sv
sv/fcr_fifo.sv
sv/fcr_front.sv
sv/fcr_back.sv
sv/fat32_cluster_chain_reader.sv
tb/sv/tb_fat32_cluster_chain_reader.sv
